// ===== rtl/core/binomial_mod_prime_lucas_defines.svh =====
// Assertion macros shared by the binomial residue block
`ifndef BINOMIAL_MOD_PRIME_LUCAS_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_LUCAS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BML_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binomial block check failed");

// antecedent implies consequent in the next cycle
`define BML_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binomial block check failed");

`endif

// ===== rtl/core/bml_pkg.sv =====
// Shared types and constants of the binomial residue block
`default_nettype none

package bml_pkg;

   localparam int VALUE_W       = 63;
   localparam int DIV_CNT_W     = 6;
   localparam int MODULUS_RESET = 65537;

   typedef enum logic [2:0] {
      MUL_NUM,
      MUL_DEN,
      MUL_PW,
      MUL_BASE,
      MUL_SMALL,
      MUL_RES
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       mul_step;
      mul_op_type mul_op;
      logic       dig_init;
      logic       i_inc;
      logic       pow_init;
      logic       exp_shift;
      logic       res_clear;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic p_small;
      logic div_last;
      logic mul_last;
      logic y_gt_x;
      logic i_gt_y;
      logic exp_zero;
      logic exp_bit0;
      logic more;
      logic res_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/bml_datapath.sv =====
// Datapath: modulus register, digit divider, serial modular multiplier
`default_nettype none

module bml_datapath #(
   parameter int MODULUS_BITS = 17
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_wr_en,
   input  wire [MODULUS_BITS-1:0]         csr_wr_data,
   input  wire [bml_pkg::VALUE_W-1:0]     req_top_value,
   input  wire [bml_pkg::VALUE_W-1:0]     req_choose_count,
   input  wire bml_pkg::cmd_type          cmd,
   output bml_pkg::status_type            status,
   output logic [MODULUS_BITS-1:0]        rsp_binomial_residue
);
   import bml_pkg::*;

   localparam int MB  = MODULUS_BITS;
   localparam int MCW = $clog2(MB);

   logic [MB-1:0]        modulus_ff;
   logic [VALUE_W-1:0]   a_ff, b_ff;
   logic [MB-1:0]        rem_a_ff, rem_b_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [MB-1:0]        x_ff, y_ff, i_ff;
   logic [MB-1:0]        num_ff, den_ff, pw_ff, base_ff, exp_ff, res_ff;
   logic [MB-1:0]        acc_ff;
   logic [MCW-1:0]       mul_cnt_ff;
   logic [MB-1:0]        out_ff;

   logic [MB:0]          sh_a, sh_b;
   logic                 ge_a, ge_b;
   logic [MB-1:0]        rem_a_in, rem_b_in;
   logic [MB-1:0]        op_a, op_b;
   logic [MB:0]          dbl, dbl_red, add, add_red;
   logic [MB-1:0]        acc_in;
   logic                 div_last, mul_last;

   // restoring division of both arguments by p, one quotient bit a cycle
   always_comb begin
      sh_a     = {rem_a_ff, a_ff[VALUE_W-1]};
      sh_b     = {rem_b_ff, b_ff[VALUE_W-1]};
      ge_a     = sh_a >= {1'b0, modulus_ff};
      ge_b     = sh_b >= {1'b0, modulus_ff};
      rem_a_in = ge_a ? MB'(sh_a - {1'b0, modulus_ff}) : MB'(sh_a);
      rem_b_in = ge_b ? MB'(sh_b - {1'b0, modulus_ff}) : MB'(sh_b);
   end

   always_comb begin
      unique case (cmd.mul_op)
         MUL_NUM: begin
            op_a = num_ff;
            op_b = x_ff - i_ff + MB'(1);
         end
         MUL_DEN: begin
            op_a = den_ff;
            op_b = i_ff;
         end
         MUL_PW: begin
            op_a = pw_ff;
            op_b = base_ff;
         end
         MUL_BASE: begin
            op_a = base_ff;
            op_b = base_ff;
         end
         MUL_SMALL: begin
            op_a = num_ff;
            op_b = pw_ff;
         end
         MUL_RES: begin
            op_a = res_ff;
            op_b = num_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // double-and-add over the multiplier bits, MSB first, reduced each step
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus_ff}) ? dbl - {1'b0, modulus_ff} : dbl;
      add     = {1'b0, dbl_red[MB-1:0]} + {1'b0, op_a};
      add_red = (add >= {1'b0, modulus_ff}) ? add - {1'b0, modulus_ff} : add;
      acc_in  = op_b[mul_cnt_ff] ? add_red[MB-1:0] : dbl_red[MB-1:0];
   end

   assign div_last = cmd.div_step && (div_cnt_ff == '0);
   assign mul_last = cmd.mul_step && (mul_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MB'(MODULUS_RESET);
         div_cnt_ff <= DIV_CNT_W'(VALUE_W - 1);
         mul_cnt_ff <= MCW'(MB - 1);
         acc_ff     <= '0;
         rem_a_ff   <= '0;
         rem_b_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
         if (cmd.div_step && !div_last) begin
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
            rem_a_ff   <= rem_a_in;
            rem_b_ff   <= rem_b_in;
         end else begin
            div_cnt_ff <= DIV_CNT_W'(VALUE_W - 1);
            rem_a_ff   <= '0;
            rem_b_ff   <= '0;
         end
         if (cmd.mul_step && !mul_last) begin
            mul_cnt_ff <= mul_cnt_ff - MCW'(1);
            acc_ff     <= acc_in;
         end else begin
            mul_cnt_ff <= MCW'(MB - 1);
            acc_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff   <= req_top_value;
         b_ff   <= req_choose_count;
         res_ff <= (modulus_ff < MB'(2)) ? '0 : MB'(1);
      end
      if (cmd.div_step) begin
         a_ff <= {a_ff[VALUE_W-2:0], ge_a};
         b_ff <= {b_ff[VALUE_W-2:0], ge_b};
      end
      if (div_last) begin
         x_ff <= rem_a_in;
         y_ff <= rem_b_in;
      end
      if (cmd.dig_init) begin
         num_ff <= MB'(1);
         den_ff <= MB'(1);
         i_ff   <= MB'(1);
      end
      if (cmd.i_inc) begin
         i_ff <= i_ff + MB'(1);
      end
      if (cmd.pow_init) begin
         base_ff <= den_ff;
         pw_ff   <= MB'(1);
         exp_ff  <= modulus_ff - MB'(2);
      end
      if (cmd.exp_shift) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.res_clear) begin
         res_ff <= '0;
      end
      if (mul_last) begin
         unique case (cmd.mul_op)
            MUL_NUM:   num_ff  <= acc_in;
            MUL_DEN:   den_ff  <= acc_in;
            MUL_PW:    pw_ff   <= acc_in;
            MUL_BASE:  base_ff <= acc_in;
            MUL_SMALL: num_ff  <= acc_in;
            MUL_RES:   res_ff  <= acc_in;
            default:   ;
         endcase
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   always_comb begin
      status.p_small  = modulus_ff < MB'(2);
      status.div_last = div_last;
      status.mul_last = mul_last;
      status.y_gt_x   = y_ff > x_ff;
      status.i_gt_y   = i_ff > y_ff;
      status.exp_zero = exp_ff == '0;
      status.exp_bit0 = exp_ff[0];
      status.more     = (|a_ff) || (|b_ff);
      status.res_zero = res_ff == '0;
   end

   assign rsp_binomial_residue = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bml_ctrl.sv =====
// Controller: sequences digit split, small binomials and the Fermat inverse
`default_nettype none
`include "binomial_mod_prime_lucas_defines.svh"

module bml_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  wire bml_pkg::status_type status,
   output bml_pkg::cmd_type     cmd
);
   import bml_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHK,
      ST_LOOP,
      ST_MNUM,
      ST_MDEN,
      ST_POWCHK,
      ST_MPW,
      ST_MBASE,
      ST_MSMALL,
      ST_MRES,
      ST_NEXT,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;
   logic      accept;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.mul_op    = MUL_NUM;
      cmd.load      = accept;
      cmd.div_step  = state_ff == ST_DIV;
      cmd.dig_init  = (state_ff == ST_CHK) && !status.y_gt_x;
      cmd.res_clear = (state_ff == ST_CHK) && status.y_gt_x;
      cmd.pow_init  = (state_ff == ST_LOOP) && status.i_gt_y;
      cmd.i_inc     = (state_ff == ST_MDEN) && status.mul_last;
      cmd.exp_shift = (state_ff == ST_MBASE) && status.mul_last;
      cmd.out_load  = (state_ff == ST_FIN) && slot_free;
      unique case (state_ff)
         ST_MNUM: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_NUM;
         end
         ST_MDEN: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_DEN;
         end
         ST_MPW: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_PW;
         end
         ST_MBASE: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_BASE;
         end
         ST_MSMALL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_SMALL;
         end
         ST_MRES: begin
            cmd.mul_step = 1'b1;
            cmd.mul_op   = MUL_RES;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= status.p_small ? ST_FIN : ST_DIV;
               end
            end
            ST_DIV: begin
               if (status.div_last) state_ff <= ST_CHK;
            end
            ST_CHK: begin
               state_ff <= status.y_gt_x ? ST_FIN : ST_LOOP;
            end
            ST_LOOP: begin
               state_ff <= status.i_gt_y ? ST_POWCHK : ST_MNUM;
            end
            ST_MNUM: begin
               if (status.mul_last) state_ff <= ST_MDEN;
            end
            ST_MDEN: begin
               if (status.mul_last) state_ff <= ST_LOOP;
            end
            ST_POWCHK: begin
               priority if (status.exp_zero) state_ff <= ST_MSMALL;
               else if (status.exp_bit0)     state_ff <= ST_MPW;
               else                          state_ff <= ST_MBASE;
            end
            ST_MPW: begin
               if (status.mul_last) state_ff <= ST_MBASE;
            end
            ST_MBASE: begin
               if (status.mul_last) state_ff <= ST_POWCHK;
            end
            ST_MSMALL: begin
               if (status.mul_last) state_ff <= ST_MRES;
            end
            ST_MRES: begin
               if (status.mul_last) state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               state_ff <= (status.more && !status.res_zero) ? ST_DIV : ST_FIN;
            end
            ST_FIN: begin
               if (slot_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `BML_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)
   `BML_ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_valid_ff)
   `BML_ASSERT_NOW(a_div_in_div, clock, reset, status.div_last, state_ff == ST_DIV)
   `BML_ASSERT_NOW(a_mul_in_mul, clock, reset, status.mul_last, cmd.mul_step)

endmodule

`default_nettype wire

// ===== rtl/core/binomial_mod_prime_lucas.sv =====
// Top level of the binomial residue block (Lucas digits, Fermat inverse)
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_top_value, req_choose_count
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_binomial_residue
//   csr     | in        | csr_wr_en            | csr_wr_data (modulus p)
//
// Per base-p digit: bit-serial division of both arguments, then 2*y
// products plus about 2*log2(p) for the inverse power and 2 more, each
// product computed bit-serially on one shared serial multiplier.
// One item is in flight; a finished beat waits in the output register while
// the next beat is accepted. Synchronous reset sets modulus to 65537.
`default_nettype none

module binomial_mod_prime_lucas #(
   parameter int MODULUS_BITS = 17
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire [MODULUS_BITS-1:0]      csr_wr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [bml_pkg::VALUE_W-1:0]  req_top_value,
   input  wire [bml_pkg::VALUE_W-1:0]  req_choose_count,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [MODULUS_BITS-1:0]     rsp_binomial_residue
);
   import bml_pkg::*;

   cmd_type    cmd;
   status_type status;

   bml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bml_datapath #(
      .MODULUS_BITS (MODULUS_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_top_value        (req_top_value),
      .req_choose_count     (req_choose_count),
      .cmd                  (cmd),
      .status               (status),
      .rsp_binomial_residue (rsp_binomial_residue)
   );

endmodule

`default_nettype wire

// ===== tb/binomial_mod_prime_lucas_tb.sv =====
// Self-checking testbench for the Lucas binomial residue block
`timescale 1ns / 1ps

module binomial_mod_prime_lucas_tb;
   import bml_pkg::*;

   localparam int MOD_W = 17;
   localparam longint unsigned CYCLE_LIMIT = 40_000_000;
   localparam bit [VALUE_W-1:0] VALUE_MAX = '1;
   localparam int NO_VALUE = -1;

   typedef bit [VALUE_W-1:0] value_type;
   typedef bit [MOD_W-1:0] residue_type;

   typedef struct {
      value_type top;
      value_type choose;
      int        known;   // typed-in residue, or NO_VALUE to use the predictor
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [MOD_W-1:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic [VALUE_W-1:0] req_top_value;
   logic [VALUE_W-1:0] req_choose_count;
   logic rsp_valid;
   logic rsp_stall;
   logic [MOD_W-1:0] rsp_binomial_residue;

   residue_type residue_q[$];
   longint unsigned modulus_shadow;
   longint unsigned cycle_count = 0;
   int error_count = 0;
   int beat_count;
   int send_gap_pct;
   int rsp_stall_pct;

   binomial_mod_prime_lucas #(.MODULUS_BITS(MOD_W)) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_top_value(req_top_value),
      .req_choose_count(req_choose_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_binomial_residue(rsp_binomial_residue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                               longint unsigned p);
      longint unsigned acc;
      acc = 1 % p;
      base = base % p;
      while (ex != 0) begin
         if (ex[0]) acc = (acc * base) % p;
         base = (base * base) % p;
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned digit_binomial(longint unsigned x, longint unsigned y,
                                                      longint unsigned p);
      longint unsigned num;
      longint unsigned den;
      num = 1 % p;
      den = 1 % p;
      if (y > x) return 0;
      for (longint unsigned i = 1; i <= y; i++) begin
         num = (num * ((x - i + 1) % p)) % p;
         den = (den * (i % p)) % p;
      end
      return (num * pow_mod(den, p - 2, p)) % p;
   endfunction

   function automatic residue_type lucas_residue(value_type top, value_type choose,
                                                 longint unsigned p);
      longint unsigned a;
      longint unsigned b;
      longint unsigned acc;
      a = top;
      b = choose;
      if (p < 2) return '0;
      acc = 1 % p;
      do begin
         acc = (acc * digit_binomial(a % p, b % p, p)) % p;
         a = a / p;
         b = b / p;
      end while ((a != 0 || b != 0) && acc != 0);
      return residue_type'(acc);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // pick the idle pattern from how far the run has got
   task automatic update_idling();
      if (beat_count < 40) begin
         send_gap_pct = 17;
         rsp_stall_pct = 65;
      end else if (beat_count < 80) begin
         send_gap_pct = 65;
         rsp_stall_pct = 17;
      end else begin
         send_gap_pct = 0;
         rsp_stall_pct = 0;
      end
   endtask

   task automatic send_beat(input value_type top, input value_type choose, input int known);
      update_idling();
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_top_value <= top;
      req_choose_count <= choose;
      do @(posedge clock); while (req_stall);
      if (known == NO_VALUE) residue_q.push_back(lucas_residue(top, choose, modulus_shadow));
      else residue_q.push_back(residue_type'(known));
      beat_count++;
   endtask

   task automatic write_modulus(input longint unsigned p);
      req_valid <= 1'b0;
      wait (residue_q.size() == 0);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= MOD_W'(p);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      modulus_shadow = p;
   endtask

   // choose arguments whose digit loops stay short for the current modulus
   task automatic random_beat();
      value_type top;
      value_type choose;
      value_type mix;
      top = value_type'({$urandom, $urandom});
      mix = value_type'({$urandom, $urandom});
      if (modulus_shadow <= 64) begin
         case ($urandom_range(3))
            0: choose = mix;
            1: choose = top & mix;
            2: choose = (top & mix) >> $urandom_range(62);
            default: choose = top;
         endcase
      end else begin
         if ($urandom_range(3) == 0) top = value_type'($urandom_range(200));
         choose = value_type'($urandom_range(48));
      end
      send_beat(top, choose, NO_VALUE);
   endtask

   // receive side: random stall, check every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (residue_q.size() == 0) begin
               report_mismatch($sformatf("unexpected residue %0d", rsp_binomial_residue));
            end else begin
               residue_type want;
               want = residue_q.pop_front();
               if (rsp_binomial_residue !== want)
                  report_mismatch($sformatf("residue %0d, want %0d",
                                            rsp_binomial_residue, want));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binomial_mod_prime_lucas_tb NOT OK");
         $finish;
      end
   end

   stim_row_type directed[] = '{
      '{63'd0, 63'd0, 1},
      '{63'd5, 63'd2, 10},
      '{63'd10, 63'd3, 120},
      '{VALUE_MAX, 63'd0, 1},
      '{63'd0, VALUE_MAX, 0},
      '{63'd3, 63'd5, 0},
      '{63'd65537, 63'd1, 0},
      '{63'd100, 63'd50, NO_VALUE},
      '{63'd1 << 62, 63'd1, NO_VALUE},
      '{VALUE_MAX, 63'd17, NO_VALUE},
      '{63'd65536, 63'd7, NO_VALUE}
   };

   longint unsigned phase_moduli[] = '{2, 3, 131071, 7, 0, 31, 1, 4, 13, 65537};

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_top_value = '0;
      req_choose_count = '0;
      beat_count = 0;
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      modulus_shadow = MODULUS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_beat(directed[i].top, directed[i].choose, directed[i].known);

      foreach (phase_moduli[k]) begin
         write_modulus(phase_moduli[k]);
         // extremes of both fields where the digit loops stay short
         if (modulus_shadow <= 64) begin
            send_beat(VALUE_MAX, VALUE_MAX, modulus_shadow < 2 ? 0 : NO_VALUE);
            send_beat(VALUE_MAX, VALUE_MAX - 1, NO_VALUE);
         end
         send_beat(VALUE_MAX, 63'd0, modulus_shadow < 2 ? 0 : NO_VALUE);
         repeat (7) random_beat();
      end
      req_valid <= 1'b0;

      wait (residue_q.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("binomial_mod_prime_lucas_tb OK");
      else
         $display("binomial_mod_prime_lucas_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bml_pkg.sv
rtl/core/bml_datapath.sv
rtl/core/bml_ctrl.sv
rtl/core/binomial_mod_prime_lucas.sv
tb/binomial_mod_prime_lucas_tb.sv
